FILE: rtl/wbps_pkg.sv
package wbps_pkg;

    localparam int MAX_PATTERN_DEF   = 32;
    localparam int POSITION_BITS_DEF = 48;

    localparam int ADDR_W    = 64;
    localparam int LEN_W     = 6;
    localparam int OFFSET_W  = 32;
    localparam int PAT_WORDS = 4;
    localparam int PAT_BYTES = 32;

    localparam logic [7:0] WILDCARD_BYTE = 8'h3F;

    typedef enum logic [2:0] {
        REG_PATTERN_WORD0  = 3'd0,
        REG_PATTERN_WORD1  = 3'd1,
        REG_PATTERN_WORD2  = 3'd2,
        REG_PATTERN_WORD3  = 3'd3,
        REG_PATTERN_LENGTH = 3'd4,
        REG_REGION_BASE    = 3'd5,
        REG_RESULT_OFFSET  = 3'd6
    } cfg_reg_t;

    // Settings derived from the register file, ready for the datapath.
    typedef struct packed {
        logic [LEN_W-1:0]  active_len;  // clamped pattern length
        logic [ADDR_W-1:0] addr_bias;   // region base plus sign-extended offset
    } cfg_derived_t;

endpackage

FILE: rtl/wbps_cfg.sv
module wbps_cfg #(
    parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    input  logic [2:0]                cfg_index,
    input  logic [63:0]               cfg_data,
    output logic [7:0]                aligned_pattern [MAX_PATTERN],
    output wbps_pkg::cfg_derived_t    derived
);

    logic [63:0]                      pattern_word_reg [wbps_pkg::PAT_WORDS];
    logic [wbps_pkg::LEN_W-1:0]       pattern_length_reg;
    logic [wbps_pkg::ADDR_W-1:0]      region_base_reg;
    logic [wbps_pkg::OFFSET_W-1:0]    result_offset_reg;

    logic [7:0]                       pattern_bytes [wbps_pkg::PAT_BYTES];
    logic [wbps_pkg::LEN_W-1:0]       active_len;
    logic [7:0]                       aligned_next [MAX_PATTERN];
    logic [7:0]                       aligned_reg  [MAX_PATTERN];
    wbps_pkg::cfg_derived_t           derived_next;
    wbps_pkg::cfg_derived_t           derived_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < wbps_pkg::PAT_WORDS; w++)
            begin
                pattern_word_reg[w] <= '0;
            end
            pattern_length_reg <= wbps_pkg::LEN_W'(1);
            region_base_reg    <= '0;
            result_offset_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                wbps_pkg::REG_PATTERN_WORD0:  pattern_word_reg[0] <= cfg_data;
                wbps_pkg::REG_PATTERN_WORD1:  pattern_word_reg[1] <= cfg_data;
                wbps_pkg::REG_PATTERN_WORD2:  pattern_word_reg[2] <= cfg_data;
                wbps_pkg::REG_PATTERN_WORD3:  pattern_word_reg[3] <= cfg_data;
                wbps_pkg::REG_PATTERN_LENGTH:
                    pattern_length_reg <= cfg_data[wbps_pkg::LEN_W-1:0];
                wbps_pkg::REG_REGION_BASE:    region_base_reg <= cfg_data;
                wbps_pkg::REG_RESULT_OFFSET:
                    result_offset_reg <= cfg_data[wbps_pkg::OFFSET_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < wbps_pkg::PAT_BYTES; i++)
        begin
            pattern_bytes[i] = pattern_word_reg[i / 8][(i % 8) * 8 +: 8];
        end
    end

    // Zero length acts as one, anything above the window acts as full window.
    always_comb
    begin
        if (pattern_length_reg == '0)
        begin
            active_len = wbps_pkg::LEN_W'(1);
        end
        else if (pattern_length_reg > wbps_pkg::LEN_W'(MAX_PATTERN))
        begin
            active_len = wbps_pkg::LEN_W'(MAX_PATTERN);
        end
        else
        begin
            active_len = pattern_length_reg;
        end
    end

    // Pattern reversed so window entry j lines up with entry j; unused slots wild.
    always_comb
    begin
        logic [wbps_pkg::LEN_W-1:0] src;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            src = active_len - wbps_pkg::LEN_W'(1) - wbps_pkg::LEN_W'(j);
            if (wbps_pkg::LEN_W'(j) < active_len)
            begin
                aligned_next[j] = pattern_bytes[src[4:0]];
            end
            else
            begin
                aligned_next[j] = wbps_pkg::WILDCARD_BYTE;
            end
        end
    end

    always_comb
    begin
        derived_next.active_len = active_len;
        derived_next.addr_bias  = region_base_reg
                                + {{(wbps_pkg::ADDR_W - wbps_pkg::OFFSET_W)
                                    {result_offset_reg[wbps_pkg::OFFSET_W-1]}},
                                   result_offset_reg};
    end

    always_ff @(posedge clk)
    begin
        aligned_reg <= aligned_next;
        derived_reg <= derived_next;
    end

    assign aligned_pattern = aligned_reg;
    assign derived         = derived_reg;

endmodule

FILE: rtl/wildcard_byte_pattern_search.sv
// Wildcard byte pattern search. A region streams in one byte per transaction
// on the slave side, tlast on its final byte. The block compares the latest
// bytes with a pattern of up to MAX_PATTERN bytes (register pattern_length),
// where a pattern byte of 0x3F matches anything, and gives at most one result
// transaction per region: tuser=1 with base + start position + signed offset
// (mod 2^64) at the first match, or tuser=0 with address 0 when the region ends
// without one. Bytes after a match are consumed silently. Throughput is one
// byte per clock unless the output stalls; a result passes three registers
// (window register, compare register, address adder register). Configuration
// writes are always accepted and take effect after the register file and a
// settings register; write only while no transaction is in flight. Once the
// position count reaches 2^POSITION_BITS - 1 the region's rest is not compared.
module wildcard_byte_pattern_search #(
    parameter int MAX_PATTERN   = wbps_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_BITS = wbps_pkg::POSITION_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // byte stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    // search result out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] match_address
    output logic        m_axis_tuser    // [0] found
);

    localparam logic [POSITION_BITS-1:0] COUNT_MAX = '1;

    logic [7:0]                 aligned_pattern [MAX_PATTERN];
    wbps_pkg::cfg_derived_t     cfg_derived;

    // stage 1: sliding window and position count
    logic                       s1_valid_reg;
    logic                       s1_last_reg;
    logic                       s1_counted_reg;
    logic [POSITION_BITS-1:0]   s1_count_reg;
    logic [POSITION_BITS-1:0]   s1_count_next;
    logic                       s1_counted_next;
    logic [POSITION_BITS-1:0]   count_base;
    logic [7:0]                 window_reg  [MAX_PATTERN];
    logic [7:0]                 window_next [MAX_PATTERN];

    // stage 2: compare outcome
    logic                       s2_valid_reg;
    logic                       s2_found_reg;
    logic [POSITION_BITS-1:0]   s2_start_reg;
    logic                       match_reported_reg;
    logic                       match_reported_next;

    // output register
    logic                       out_valid_reg;
    logic                       out_found_reg;
    logic [wbps_pkg::ADDR_W-1:0] out_addr_reg;

    logic                       s_accept;
    logic                       out_free;
    logic                       s2_free;
    logic                       s1_take;
    logic                       window_hit;
    logic                       long_enough;
    logic                       match_hit;
    logic                       has_result;

    wbps_cfg #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .aligned_pattern (aligned_pattern),
        .derived         (cfg_derived)
    );

    assign cfg_ready = 1'b1;

    // Ready chain: each stage frees when the one after it can take its content.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s2_free       = !s2_valid_reg || out_free;
    assign s1_take       = s1_valid_reg && s2_free;
    assign s_axis_tready = !s1_valid_reg || s2_free;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // A region boundary is applied lazily: the byte after tlast restarts the count.
    // Window entries past the count are never compared, so they are not cleared.
    always_comb
    begin
        count_base = s1_last_reg ? '0 : s1_count_reg;
        if (count_base != COUNT_MAX)
        begin
            s1_count_next   = count_base + POSITION_BITS'(1);
            s1_counted_next = 1'b1;
        end
        else
        begin
            s1_count_next   = count_base;
            s1_counted_next = 1'b0;
        end
        window_next[0] = s_axis_tdata;
        for (int j = 1; j < MAX_PATTERN; j++)
        begin
            window_next[j] = window_reg[j-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s1_last_reg    <= 1'b0;
            s1_counted_reg <= 1'b0;
            s1_count_reg   <= '0;
        end
        else
        begin
            if (s_accept)
            begin
                s1_valid_reg   <= 1'b1;
                s1_last_reg    <= s_axis_tlast;
                s1_counted_reg <= s1_counted_next;
                s1_count_reg   <= s1_count_next;
            end
            else if (s1_take)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            window_reg <= window_next;
        end
    end

    // Window compare against the pre-aligned pattern; slots beyond the length are wild.
    always_comb
    begin
        window_hit = 1'b1;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            if (aligned_pattern[j] != wbps_pkg::WILDCARD_BYTE
                && aligned_pattern[j] != window_reg[j])
            begin
                window_hit = 1'b0;
            end
        end
    end

    assign long_enough = s1_count_reg >= POSITION_BITS'(cfg_derived.active_len);
    assign match_hit   = !match_reported_reg && s1_counted_reg && long_enough && window_hit;
    assign has_result  = match_hit || (s1_last_reg && !match_reported_reg);

    always_comb
    begin
        if (s1_last_reg)
        begin
            match_reported_next = 1'b0;
        end
        else
        begin
            match_reported_next = match_reported_reg || match_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg       <= 1'b0;
            match_reported_reg <= 1'b0;
        end
        else
        begin
            if (s1_take)
            begin
                match_reported_reg <= match_reported_next;
                s2_valid_reg       <= has_result;
            end
            else if (out_free)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            s2_found_reg <= match_hit;
            s2_start_reg <= s1_count_reg - POSITION_BITS'(cfg_derived.active_len);
        end
    end

    // Output register: the address add sits here, off the compare path.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_valid_reg && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && out_free)
        begin
            out_found_reg <= s2_found_reg;
            if (s2_found_reg)
            begin
                out_addr_reg <= cfg_derived.addr_bias
                              + wbps_pkg::ADDR_W'(s2_start_reg);
            end
            else
            begin
                out_addr_reg <= '0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_addr_reg;
    assign m_axis_tuser  = out_found_reg;

endmodule

FILE: rtl/wbps_checker.sv
module wbps_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result transaction dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result payload changed while stalled");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 64'd0)
        else $error("no-match result with nonzero address");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

endmodule

bind wildcard_byte_pattern_search wbps_checker u_wbps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/sv/tb_wildcard_byte_pattern_search.sv
module tb_wildcard_byte_pattern_search;

    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------
    // Constants
    // ------------------------------------------------------------------
    localparam int          POS_W        = wbps_pkg::POSITION_BITS_DEF;
    localparam logic [POS_W-1:0] SEEN_MAX = '1;
    localparam logic [2:0]  REG_UNMAPPED = 3'd7;  // no register behind it
    localparam int          HOLD_CYCLES  = 300;   // long sink hold-off
    localparam int          NUM_PHASES   = 13;
    localparam int          PHASE_BYTES  = 45;
    localparam int          SETTLE       = 8;     // > 3-stage pipeline depth
    localparam int          HOLD_AT_A    = 250;
    localparam int          HOLD_AT_B    = 550;

    typedef struct packed {
        logic        found;
        logic [63:0] addr;
    } search_result_t;

    typedef enum logic [1:0] {
        CHK_MODEL,   // expectation from the predictor
        CHK_SILENT,  // no result may come from this byte
        CHK_TYPED    // expectation written into the table
    } chk_t;

    typedef enum logic {
        ROW_WRITE,
        ROW_BYTE
    } row_kind_t;

    typedef struct {
        row_kind_t      kind;
        logic [2:0]     idx;
        logic [63:0]    value;
        logic [7:0]     data;
        logic           last;
        chk_t           chk;
        search_result_t typed;
    } stim_row_t;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index     = '0;
    logic [63:0] cfg_data      = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] data_byte
    logic        s_axis_tlast  = 1'b0; // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;         // [63:0] match_address
    logic        m_axis_tuser;         // [0] found

    wildcard_byte_pattern_search u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Register mirror and search state of the predictor
    // ------------------------------------------------------------------
    logic [255:0]                pat_bits      = '0;    // pattern byte i at [8i+7:8i]
    logic [wbps_pkg::LEN_W-1:0]  pat_len       = 6'd1;
    logic [63:0]                 region_base   = '0;
    logic [31:0]                 result_offset = '0;

    logic [7:0]        win [wbps_pkg::PAT_BYTES];   // newest byte at entry 0
    logic [POS_W-1:0]  seen     = '0;
    bit                reported = 1'b0;

    search_result_t    pending_search_results [$];
    stim_row_t         directed_rows [$];

    // bookkeeping
    int bytes_sent;
    int regions_sent;
    int cfg_writes;
    int hits_checked;
    int misses_checked;
    int mismatches;
    int input_stalls;
    int hold_asks;
    int holds_done;
    int burst_left;

    initial begin
        for (int i = 0; i < wbps_pkg::PAT_BYTES; i++)
            win[i] = '0;
    end

    // Length 0 runs as 1, anything above the window size as the window size.
    function automatic int active_len(input logic [wbps_pkg::LEN_W-1:0] n);
        if (n == 0)
            return 1;
        if (n > wbps_pkg::PAT_BYTES)
            return wbps_pkg::PAT_BYTES;
        return int'(n);
    endfunction

    function automatic void apply_write(input logic [2:0] idx, input logic [63:0] val);
        case (idx)
            wbps_pkg::REG_PATTERN_WORD0:  pat_bits[0   +: 64] = val;
            wbps_pkg::REG_PATTERN_WORD1:  pat_bits[64  +: 64] = val;
            wbps_pkg::REG_PATTERN_WORD2:  pat_bits[128 +: 64] = val;
            wbps_pkg::REG_PATTERN_WORD3:  pat_bits[192 +: 64] = val;
            wbps_pkg::REG_PATTERN_LENGTH: pat_len = val[wbps_pkg::LEN_W-1:0];
            wbps_pkg::REG_REGION_BASE:    region_base         = val;
            wbps_pkg::REG_RESULT_OFFSET:  result_offset       = val[31:0];
            default: ;  // unmapped index: dropped
        endcase
    endfunction

    // Shift one byte into the window and work out the result it causes.
    // Returns 1 when a result is due.
    function automatic bit predict_search(input logic [7:0] d, input logic l,
                                          output search_result_t r);
        int         len;
        bit         counted;
        bit         hit;
        bit         due;
        logic [7:0] p;
        logic [7:0] b;

        len     = active_len(pat_len);
        counted = 1'b0;
        due     = 1'b0;
        r       = '0;

        for (int i = wbps_pkg::PAT_BYTES - 1; i > 0; i--)
            win[i] = win[i-1];
        win[0] = d;

        // position count saturates; past that point nothing is compared
        if (seen != SEEN_MAX) begin
            seen++;
            counted = 1'b1;
        end

        if (!reported && counted && 64'(seen) >= 64'(len)) begin
            hit = 1'b1;
            for (int i = 0; i < len; i++) begin
                p = pat_bits[i*8 +: 8];
                b = win[len-1-i];
                if (p != wbps_pkg::WILDCARD_BYTE && p != b)
                    hit = 1'b0;
            end
            if (hit) begin
                r.found  = 1'b1;
                r.addr   = region_base + (64'(seen) - 64'(len))
                         + {{32{result_offset[31]}}, result_offset};
                reported = 1'b1;
                due      = 1'b1;
            end
        end

        if (l) begin
            if (!reported) begin
                r   = '0;
                due = 1'b1;
            end
            for (int i = 0; i < wbps_pkg::PAT_BYTES; i++)
                win[i] = '0;
            seen     = '0;
            reported = 1'b0;
        end
        return due;
    endfunction

    // ------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------
    function automatic void add_write(input logic [2:0] idx, input logic [63:0] val);
        stim_row_t row;
        row.kind  = ROW_WRITE;
        row.idx   = idx;
        row.value = val;
        row.data  = '0;
        row.last  = 1'b0;
        row.chk   = CHK_MODEL;
        row.typed = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_byte(input logic [7:0] d, input logic l, input chk_t chk,
                                     input logic found, input logic [63:0] addr);
        stim_row_t row;
        row.kind        = ROW_BYTE;
        row.idx         = '0;
        row.value       = '0;
        row.data        = d;
        row.last        = l;
        row.chk         = chk;
        row.typed.found = found;
        row.typed.addr  = addr;
        directed_rows.push_back(row);
    endfunction

    // ------------------------------------------------------------------
    // Byte source: one transaction per call, bursts with random gaps.
    // tvalid stays high into the next call inside a burst.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] d, input logic l, input chk_t chk,
                             input search_result_t typed);
        search_result_t r;
        bit             due;

        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tlast  <= l;
        do
            @(posedge clk);
        while (!s_axis_tready);

        due = predict_search(d, l, r);
        case (chk)
            CHK_MODEL: if (due) pending_search_results.push_back(r);
            CHK_TYPED: pending_search_results.push_back(typed);
            default: ;
        endcase

        bytes_sent++;
        if (l)
            regions_sent++;
        // ask the sink for a long hold-off while bytes keep coming
        if (bytes_sent == HOLD_AT_A || bytes_sent == HOLD_AT_B)
            hold_asks++;

        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
        end else begin
            burst_left--;
        end
    endtask

    // Stop the byte stream, let every expected result arrive, then let the
    // pipeline empty of bytes that cause none.
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (pending_search_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_write(idx, val);
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result sink: own stall pattern, plus the long hold-offs on request
    // ------------------------------------------------------------------
    initial begin
        int mode;
        int mode_left;
        mode      = 0;
        mode_left = 0;
        forever begin
            @(posedge clk);
            if (holds_done != hold_asks) begin
                holds_done++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            case (mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each result transaction against the oldest expectation
    // ------------------------------------------------------------------
    search_result_t want;

    always @(posedge clk) begin
        if (rst_n && s_axis_tvalid && !s_axis_tready)
            input_stalls++;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_search_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result found=%b addr=%h",
                             $realtime, m_axis_tuser, m_axis_tdata);
            end else begin
                want = pending_search_results.pop_front();
                if (m_axis_tuser !== want.found || m_axis_tdata !== want.addr) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result mismatch found exp=%b got=%b addr exp=%h got=%h",
                                 $realtime, want.found, m_axis_tuser, want.addr,
                                 m_axis_tdata);
                end else if (want.found) begin
                    hits_checked++;
                end else begin
                    misses_checked++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Run limit
    // ------------------------------------------------------------------
    initial begin
        #4ms;
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        search_result_t none;
        logic [7:0]     region_q [$];
        logic [255:0]   new_pat;
        logic [63:0]    new_base;
        logic [31:0]    new_off;
        logic [7:0]     pb;
        logic [wbps_pkg::LEN_W-1:0] new_len;
        int             len;
        int             kind;
        int             phase_bytes;
        int             flip;

        none       = '0;
        burst_left = 0;

        // Directed part. Reset pattern is a single 0x00 byte, base 0, offset 0.
        add_byte(8'h00, 1'b1, CHK_TYPED, 1'b1, 64'h0);        // one-byte hit
        add_byte(8'hFF, 1'b1, CHK_TYPED, 1'b0, 64'h0);        // one-byte miss
        add_byte(8'hFF, 1'b0, CHK_SILENT, 1'b0, 64'h0);
        add_byte(8'h00, 1'b1, CHK_TYPED, 1'b1, 64'h1);        // hit at position 1
        add_write(REG_UNMAPPED, '1);                          // must be dropped
        add_byte(8'h00, 1'b1, CHK_TYPED, 1'b1, 64'h0);
        // 3-byte pattern AA ? 55
        add_write(wbps_pkg::REG_PATTERN_WORD0, 64'h0000_0000_0055_3FAA);
        add_write(wbps_pkg::REG_PATTERN_LENGTH, 64'd3);
        add_byte(8'hAA, 1'b0, CHK_SILENT, 1'b0, 64'h0);
        add_byte(8'h3F, 1'b0, CHK_SILENT, 1'b0, 64'h0);
        add_byte(8'h55, 1'b1, CHK_TYPED, 1'b1, 64'h0);
        add_byte(8'hAA, 1'b0, CHK_SILENT, 1'b0, 64'h0);       // region shorter than pattern
        add_byte(8'h00, 1'b1, CHK_TYPED, 1'b0, 64'h0);
        // all-ones base with most negative offset, hit on the flagged byte
        add_write(wbps_pkg::REG_REGION_BASE, '1);
        add_write(wbps_pkg::REG_RESULT_OFFSET, 64'h0000_0000_8000_0000);
        add_byte(8'h01, 1'b0, CHK_SILENT, 1'b0, 64'h0);
        add_byte(8'hAA, 1'b0, CHK_SILENT, 1'b0, 64'h0);
        add_byte(8'hEE, 1'b0, CHK_SILENT, 1'b0, 64'h0);
        add_byte(8'h55, 1'b1, CHK_TYPED, 1'b1, 64'hFFFF_FFFF_8000_0000);
        // bytes after a hit are consumed silently, region still ends
        add_byte(8'hAA, 1'b0, CHK_SILENT, 1'b0, 64'h0);
        add_byte(8'hFF, 1'b0, CHK_SILENT, 1'b0, 64'h0);
        add_byte(8'h55, 1'b0, CHK_TYPED, 1'b1, 64'hFFFF_FFFF_7FFF_FFFF);
        add_byte(8'h00, 1'b0, CHK_SILENT, 1'b0, 64'h0);
        add_byte(8'h3F, 1'b1, CHK_SILENT, 1'b0, 64'h0);
        // length 0 runs as 1, largest positive offset
        add_write(wbps_pkg::REG_PATTERN_WORD0, '1);
        add_write(wbps_pkg::REG_PATTERN_WORD1, 64'h3F3F_3F3F_3F3F_3F3F);
        add_write(wbps_pkg::REG_PATTERN_WORD2, '0);
        add_write(wbps_pkg::REG_PATTERN_WORD3, '1);
        add_write(wbps_pkg::REG_PATTERN_LENGTH, 64'd0);
        add_write(wbps_pkg::REG_REGION_BASE, 64'h0);
        add_write(wbps_pkg::REG_RESULT_OFFSET, 64'h0000_0000_7FFF_FFFF);
        add_byte(8'h7F, 1'b0, CHK_MODEL, 1'b0, 64'h0);
        add_byte(8'hFF, 1'b1, CHK_MODEL, 1'b0, 64'h0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                quiesce();
                cfg_write(directed_rows[i].idx, directed_rows[i].value);
            end else begin
                send_byte(directed_rows[i].data, directed_rows[i].last,
                          directed_rows[i].chk, directed_rows[i].typed);
            end
        end

        // Random part: a fresh setting per phase, lengths walk the extremes.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            for (int i = 0; i < wbps_pkg::PAT_BYTES; i++)
                new_pat[i*8 +: 8] = ($urandom_range(0, 3) == 0)
                                  ? wbps_pkg::WILDCARD_BYTE
                                  : 8'($urandom);
            case (ph % 7)
                0:       new_len = 6'd1;
                1:       new_len = 6'd32;
                2:       new_len = 6'd0;
                3:       new_len = 6'd63;
                4:       new_len = 6'd33;
                5:       new_len = 6'($urandom_range(2, 8));
                default: new_len = 6'($urandom_range(1, 32));
            endcase
            case ($urandom_range(0, 3))
                0:       new_base = '0;
                1:       new_base = '1;
                default: new_base = {$urandom, $urandom};
            endcase
            case ($urandom_range(0, 3))
                0:       new_off = 32'h8000_0000;
                1:       new_off = 32'h7FFF_FFFF;
                default: new_off = $urandom;
            endcase

            quiesce();
            cfg_write(wbps_pkg::REG_PATTERN_WORD0, new_pat[0   +: 64]);
            cfg_write(wbps_pkg::REG_PATTERN_WORD1, new_pat[64  +: 64]);
            cfg_write(wbps_pkg::REG_PATTERN_WORD2, new_pat[128 +: 64]);
            cfg_write(wbps_pkg::REG_PATTERN_WORD3, new_pat[192 +: 64]);
            cfg_write(wbps_pkg::REG_PATTERN_LENGTH, 64'(new_len));
            cfg_write(wbps_pkg::REG_REGION_BASE, new_base);
            cfg_write(wbps_pkg::REG_RESULT_OFFSET, 64'(new_off));
            if ($urandom_range(0, 3) == 0)
                cfg_write(REG_UNMAPPED, {$urandom, $urandom});

            len         = active_len(pat_len);
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                region_q.delete();
                kind = $urandom_range(0, 9);
                if (kind == 8 && len > 1) begin
                    // too short to hold the pattern
                    repeat ($urandom_range(1, len - 1))
                        region_q.push_back(8'($urandom));
                end else if (kind >= 6) begin
                    // plain noise
                    repeat ($urandom_range(1, 24))
                        region_q.push_back(8'($urandom));
                end else begin
                    // prefix, pattern copy with random wildcard fill, suffix
                    repeat ($urandom_range(0, 8))
                        region_q.push_back(8'($urandom));
                    flip = (kind == 5) ? $urandom_range(0, len - 1) : -1;
                    for (int i = 0; i < len; i++) begin
                        pb = pat_bits[i*8 +: 8];
                        if (pb == wbps_pkg::WILDCARD_BYTE)
                            pb = 8'($urandom);
                        else if (i == flip)
                            pb = pb ^ 8'($urandom_range(1, 255));  // broken copy
                        region_q.push_back(pb);
                    end
                    repeat ($urandom_range(0, 5))
                        region_q.push_back(8'($urandom));
                end
                foreach (region_q[i])
                    send_byte(region_q[i], i == region_q.size() - 1, CHK_MODEL, none);
                phase_bytes += region_q.size();
            end
        end

        quiesce();
        repeat (20) @(posedge clk);

        $display("Scanned %0d bytes in %0d regions with %0d register writes",
                 bytes_sent, regions_sent, cfg_writes);
        $display("Checked %0d matches and %0d misses; input stalled %0d cycles; %0d errors",
                 hits_checked, misses_checked, input_stalls, mismatches);
        if (mismatches == 0 && pending_search_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: wildcard_byte_pattern_search.f
rtl/wbps_pkg.sv
rtl/wbps_cfg.sv
rtl/wildcard_byte_pattern_search.sv
rtl/wbps_checker.sv
tb/sv/tb_wildcard_byte_pattern_search.sv
